// File: src/imusbd_pkg.sv
// constants shared by the imu smoothing and brake detector block
// operation codes, configuration register indexes, register widths and reset values
// no dependencies
package imusbd_pkg;

    localparam int NUM_AXES = 9;

    // operation codes
    localparam logic [1:0] OP_SAMPLE = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_REMOTE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BRAKE_THRESHOLD = 2'd0;
    localparam logic [1:0] CFG_JERK_THRESHOLD  = 2'd1;
    localparam logic [1:0] CFG_HOLD_TICKS      = 2'd2;
    localparam logic [1:0] CFG_SMOOTH_SHIFT    = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int BRAKE_W     = 15;
    localparam int JERK_W      = 16;
    localparam int HOLD_W      = 8;
    localparam int SHIFT_W     = 3;

    localparam logic [BRAKE_W-1:0] BRAKE_RESET = 15'd1638;
    localparam logic [JERK_W-1:0]  JERK_RESET  = 16'd4915;
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 8'd25;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 3'd1;

    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 3'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 3'd4;

endpackage

// File: src/imu_smoothing_brake_detector_core.sv
// imu smoothing filter with brake warning detector, top level
// nine first-order smoothing filters, brake and jerk compares and a warning hold counter
// depends on imusbd_pkg
//
//  channel   direction  handshake                  payload
//  in        sink       in_valid / in_ready        operation, nine raw axes
//  out       source     out_valid / out_ready      nine filtered axes, warning_active, triggered_now
//  cfg       sink       cfg_write_en               cfg_index, cfg_data
//
// one item a cycle while out_ready is high: the filter, compare and counter logic sits between the state
// registers and the result register, so each result appears in the cycle after its transfer
// in_ready is low only while a result is held and out_ready is low
// reset clears the filters, previous values and hold counter, sets the seeding flag, and loads
// the configuration reset values; no clearing pass
module imu_smoothing_brake_detector_core #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [1:0]                          operation,
    input  logic signed [SAMPLE_WIDTH-1:0]      accel_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      accel_y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      accel_z_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      gyro_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      gyro_y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      gyro_z_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      mag_x_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      mag_y_in,
    input  logic signed [SAMPLE_WIDTH-1:0]      mag_z_in,

    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]      accel_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]      accel_y_out,
    output logic signed [SAMPLE_WIDTH-1:0]      accel_z_out,
    output logic signed [SAMPLE_WIDTH-1:0]      gyro_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]      gyro_y_out,
    output logic signed [SAMPLE_WIDTH-1:0]      gyro_z_out,
    output logic signed [SAMPLE_WIDTH-1:0]      mag_x_out,
    output logic signed [SAMPLE_WIDTH-1:0]      mag_y_out,
    output logic signed [SAMPLE_WIDTH-1:0]      mag_z_out,
    output logic                                warning_active,
    output logic                                triggered_now,

    input  logic                                cfg_write_en,
    input  logic [imusbd_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [imusbd_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int W     = SAMPLE_WIDTH;
    // compare width, always at least two bits above sample and threshold widths
    localparam int CMP_W = ((W > imusbd_pkg::JERK_W) ? W : imusbd_pkg::JERK_W) + 2;
    localparam logic [W-1:0] MAX_POS = {1'b0, {(W-1){1'b1}}};

    // configuration registers
    logic [imusbd_pkg::BRAKE_W-1:0] brake_thr_reg;
    logic [imusbd_pkg::JERK_W-1:0]  jerk_thr_reg;
    logic [imusbd_pkg::HOLD_W-1:0]  hold_ticks_reg;
    logic [imusbd_pkg::SHIFT_W-1:0] shift_reg;

    // block state
    logic signed [W-1:0]            filt_reg [imusbd_pkg::NUM_AXES];
    logic signed [W-1:0]            filt_next [imusbd_pkg::NUM_AXES];
    logic signed [W-1:0]            prev_x_reg;
    logic signed [W-1:0]            prev_y_reg;
    logic signed [W-1:0]            prev_x_next;
    logic signed [W-1:0]            prev_y_next;
    logic                           seed_reg;
    logic                           seed_next;
    logic [imusbd_pkg::HOLD_W-1:0]  hold_reg;
    logic [imusbd_pkg::HOLD_W-1:0]  hold_next;

    // result register
    logic                           out_valid_reg;
    logic signed [W-1:0]            res_axes_reg [imusbd_pkg::NUM_AXES];
    logic                           res_warn_reg;
    logic                           res_trig_reg;

    logic signed [W-1:0]            raw [imusbd_pkg::NUM_AXES];
    logic signed [W-1:0]            upd [imusbd_pkg::NUM_AXES];
    logic [imusbd_pkg::SHIFT_W-1:0] shift_eff;
    logic                           is_sample;
    logic                           accept;
    logic                           trig;
    logic [W-1:0]                   abs_x;
    logic [W-1:0]                   abs_y;
    logic [W:0]                     jerk_x;
    logic [W:0]                     jerk_y;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign is_sample = (operation == imusbd_pkg::OP_SAMPLE);

    assign raw[0] = accel_x_in;
    assign raw[1] = accel_y_in;
    assign raw[2] = accel_z_in;
    assign raw[3] = gyro_x_in;
    assign raw[4] = gyro_y_in;
    assign raw[5] = gyro_z_in;
    assign raw[6] = mag_x_in;
    assign raw[7] = mag_y_in;
    assign raw[8] = mag_z_in;

    always_comb
    begin
        if (shift_reg < imusbd_pkg::SHIFT_MIN)
        begin
            shift_eff = imusbd_pkg::SHIFT_MIN;
        end
        else if (shift_reg > imusbd_pkg::SHIFT_MAX)
        begin
            shift_eff = imusbd_pkg::SHIFT_MAX;
        end
        else
        begin
            shift_eff = shift_reg;
        end
    end

    // one subtract, arithmetic shift and add per axis
    for (genvar i = 0; i < imusbd_pkg::NUM_AXES; i++)
    begin : g_axis
        logic signed [W:0] diff;
        logic signed [W:0] step;

        assign diff   = {raw[i][W-1], raw[i]} - {filt_reg[i][W-1], filt_reg[i]};
        assign step   = diff >>> shift_eff;
        assign upd[i] = filt_reg[i] + step[W-1:0];

        always_comb
        begin
            if (!is_sample)
            begin
                filt_next[i] = filt_reg[i];
            end
            else if (seed_reg)
            begin
                filt_next[i] = raw[i];
            end
            else
            begin
                filt_next[i] = upd[i];
            end
        end
    end

    always_comb
    begin
        if (is_sample && !seed_reg)
        begin
            prev_x_next = filt_reg[0];
            prev_y_next = filt_reg[1];
        end
        else
        begin
            prev_x_next = prev_x_reg;
            prev_y_next = prev_y_reg;
        end
        seed_next = seed_reg && !is_sample;
    end

    // saturating magnitude of the filtered x and y acceleration, and jerk magnitude against the previous values
    always_comb
    begin
        logic signed [W:0] ext_x;
        logic signed [W:0] ext_y;
        logic [W:0]        mag_xv;
        logic [W:0]        mag_yv;
        logic signed [W:0] dx;
        logic signed [W:0] dy;

        ext_x  = {filt_next[0][W-1], filt_next[0]};
        ext_y  = {filt_next[1][W-1], filt_next[1]};
        mag_xv = ext_x[W] ? -ext_x : ext_x;
        mag_yv = ext_y[W] ? -ext_y : ext_y;
        abs_x  = (mag_xv > {1'b0, MAX_POS}) ? MAX_POS : mag_xv[W-1:0];
        abs_y  = (mag_yv > {1'b0, MAX_POS}) ? MAX_POS : mag_yv[W-1:0];

        dx     = ext_x - {prev_x_next[W-1], prev_x_next};
        dy     = ext_y - {prev_y_next[W-1], prev_y_next};
        jerk_x = dx[W] ? -dx : dx;
        jerk_y = dy[W] ? -dy : dy;
    end

    always_comb
    begin
        logic [CMP_W-1:0] brake_c;
        logic [CMP_W-1:0] jerk_c;

        brake_c = {{(CMP_W-imusbd_pkg::BRAKE_W){1'b0}}, brake_thr_reg};
        jerk_c  = {{(CMP_W-imusbd_pkg::JERK_W){1'b0}}, jerk_thr_reg};
        trig    = is_sample && (
                  ({{(CMP_W-W){1'b0}}, abs_x} > brake_c) ||
                  ({{(CMP_W-W){1'b0}}, abs_y} > brake_c) ||
                  ({{(CMP_W-W-1){1'b0}}, jerk_x} > jerk_c) ||
                  ({{(CMP_W-W-1){1'b0}}, jerk_y} > jerk_c));
    end

    always_comb
    begin
        case (operation)
            imusbd_pkg::OP_SAMPLE:
            begin
                hold_next = trig ? hold_ticks_reg : hold_reg;
            end
            imusbd_pkg::OP_TICK:
            begin
                hold_next = (hold_reg != '0) ? hold_reg - 1'b1 : hold_reg;
            end
            imusbd_pkg::OP_REMOTE:
            begin
                hold_next = hold_ticks_reg;
            end
            default:
            begin
                hold_next = hold_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_thr_reg  <= imusbd_pkg::BRAKE_RESET;
            jerk_thr_reg   <= imusbd_pkg::JERK_RESET;
            hold_ticks_reg <= imusbd_pkg::HOLD_RESET;
            shift_reg      <= imusbd_pkg::SHIFT_RESET;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                imusbd_pkg::CFG_BRAKE_THRESHOLD:
                begin
                    brake_thr_reg <= cfg_data[imusbd_pkg::BRAKE_W-1:0];
                end
                imusbd_pkg::CFG_JERK_THRESHOLD:
                begin
                    jerk_thr_reg <= cfg_data[imusbd_pkg::JERK_W-1:0];
                end
                imusbd_pkg::CFG_HOLD_TICKS:
                begin
                    hold_ticks_reg <= cfg_data[imusbd_pkg::HOLD_W-1:0];
                end
                imusbd_pkg::CFG_SMOOTH_SHIFT:
                begin
                    shift_reg <= cfg_data[imusbd_pkg::SHIFT_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < imusbd_pkg::NUM_AXES; i++)
            begin
                filt_reg[i] <= '0;
            end
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            seed_reg      <= 1'b1;
            hold_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                for (int i = 0; i < imusbd_pkg::NUM_AXES; i++)
                begin
                    filt_reg[i] <= filt_next[i];
                end
                prev_x_reg <= prev_x_next;
                prev_y_reg <= prev_y_next;
                seed_reg   <= seed_next;
                hold_reg   <= hold_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, loaded on each input transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < imusbd_pkg::NUM_AXES; i++)
            begin
                res_axes_reg[i] <= filt_next[i];
            end
            res_warn_reg <= (hold_next != '0);
            res_trig_reg <= trig;
        end
    end

    assign out_valid      = out_valid_reg;
    assign accel_x_out    = res_axes_reg[0];
    assign accel_y_out    = res_axes_reg[1];
    assign accel_z_out    = res_axes_reg[2];
    assign gyro_x_out     = res_axes_reg[3];
    assign gyro_y_out     = res_axes_reg[4];
    assign gyro_z_out     = res_axes_reg[5];
    assign mag_x_out      = res_axes_reg[6];
    assign mag_y_out      = res_axes_reg[7];
    assign mag_z_out      = res_axes_reg[8];
    assign warning_active = res_warn_reg;
    assign triggered_now  = res_trig_reg;

endmodule
